### rtl/buddy_page_allocator_assert.svh
// Assertion macros for the buddy page allocator.
// Every macro expects signals named clk and rst_n in the module that uses it.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define BPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// Next-cycle implication.
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`else

`define BPA_ASSERT_IMPL(label, ante, cons)
`define BPA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int ORDER_COUNT    = 11;
  localparam int PAGE_BYTES_LOG = 10;
  localparam int PAGE_LOG       = ORDER_COUNT - 1;
  localparam int PAGE_COUNT     = 1 << PAGE_LOG;
  localparam int ORDER_W        = 4;
  localparam int STAMP_W        = 32;
  localparam int REQ_W          = 24;
  localparam int ADDR_W         = 32;
  localparam int XLEN_W         = 5;

  localparam logic [1:0] ROLE_NONE = 2'd0;
  localparam logic [1:0] ROLE_FREE = 2'd1;
  localparam logic [1:0] ROLE_USED = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [PAGE_LOG-1:0] page_t;
  typedef logic [ORDER_W-1:0]  order_t;

  typedef struct packed {
    logic [1:0]         role;
    order_t             order;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              ok;
  } res_t;

  // Bit length of ((bytes - 1) >> PAGE_BYTES_LOG): the order that holds the request.
  function automatic logic [XLEN_W-1:0] size_order(input logic [REQ_W-1:0] bytes);
    logic [REQ_W-1:0]  x;
    logic [XLEN_W-1:0] len;
    x   = (bytes - REQ_W'(1)) >> PAGE_BYTES_LOG;
    len = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (x[i]) len = XLEN_W'(i + 1);
    end
    return len;
  endfunction

endpackage
`default_nettype wire

### rtl/bpa_ram.sv
`default_nettype none
module bpa_ram #(
  parameter int AW = 10,
  parameter int DW = 38
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/bpa_engine.sv
`default_nettype none
`include "buddy_page_allocator_assert.svh"
module bpa_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          init,
  input  wire logic [bpa_pkg::ADDR_W-1:0]    base_address,
  input  wire bpa_pkg::order_t               pool_order,
  input  wire logic                          start,
  input  wire logic                          kind,
  input  wire logic [bpa_pkg::REQ_W-1:0]     request_bytes,
  input  wire logic [bpa_pkg::ADDR_W-1:0]    release_address,
  output logic                               ready,
  output bpa_pkg::res_t                      res
);
  import bpa_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ASCAN  = 4'd2;
  localparam logic [3:0] S_APICK  = 4'd3;
  localparam logic [3:0] S_ASPLIT = 4'd4;
  localparam logic [3:0] S_FLOOK  = 4'd5;
  localparam logic [3:0] S_MSCAN  = 4'd6;
  localparam logic [3:0] S_MKILL  = 4'd7;
  localparam logic [3:0] S_MPUSH  = 4'd8;

  localparam order_t TOP_ORDER = ORDER_W'(ORDER_COUNT - 1);

  logic [3:0]         state_r, state_nxt;
  page_t              cnt_r, cnt_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               rd_vld_r;
  page_t              rd_page_r;
  logic [STAMP_W-1:0] stamp_ctr_r, stamp_ctr_nxt;
  order_t             ord_r, ord_nxt;
  order_t             cur_r, cur_nxt;
  page_t              page_r, page_nxt;
  logic [STAMP_W-1:0] pstamp_r, pstamp_nxt;

  logic               lane_found_r [ORDER_COUNT];
  page_t              lane_page_r  [ORDER_COUNT];
  logic [STAMP_W-1:0] lane_stamp_r [ORDER_COUNT];

  logic               mfound_r, mfound_nxt;
  page_t              mpage_r, mpage_nxt;
  logic [STAMP_W-1:0] mstamp_r, mstamp_nxt;
  logic               pend_r, pend_nxt;
  logic [STAMP_W-1:0] pend_stamp_r, pend_stamp_nxt;

  logic               wr_en;
  page_t              wr_addr;
  entry_t             wr_data;
  logic               rd_en;
  page_t              rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t             rd_data;

  logic [XLEN_W-1:0]  req_order;
  logic [ADDR_W-1:0]  rel_off;
  logic               scan_issue;
  logic [PAGE_LOG:0]  span_w;
  logic [PAGE_LOG:0]  mask_w;
  page_t              span;
  page_t              mask;
  logic               pick_found;
  order_t             pick_ord;

  bpa_ram #(.AW(PAGE_LOG), .DW(ENTRY_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_data)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_data   = entry_t'(rd_raw);
  assign req_order = size_order(request_bytes);
  assign rel_off   = release_address - base_address;
  assign span_w    = (PAGE_LOG+1)'(1) << ord_r;
  assign mask_w    = (span_w << 1) - (PAGE_LOG+1)'(1);
  assign span      = span_w[PAGE_LOG-1:0];
  assign mask      = mask_w[PAGE_LOG-1:0];
  assign ready     = (state_r == S_IDLE);
  assign scan_issue = ((state_r == S_ASCAN) || (state_r == S_MSCAN)) && !issue_done_r;

  // Smallest sufficient order that holds a free block.
  always_comb begin
    pick_found = 1'b0;
    pick_ord   = '0;
    for (int o = ORDER_COUNT - 1; o >= 0; o--) begin
      if (lane_found_r[o] && (ORDER_W'(o) >= ord_r)) begin
        pick_found = 1'b1;
        pick_ord   = ORDER_W'(o);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    issue_done_nxt = issue_done_r;
    stamp_ctr_nxt  = stamp_ctr_r;
    ord_nxt        = ord_r;
    cur_nxt        = cur_r;
    page_nxt       = page_r;
    pstamp_nxt     = pstamp_r;
    mfound_nxt     = mfound_r;
    mpage_nxt      = mpage_r;
    mstamp_nxt     = mstamp_r;
    pend_nxt       = pend_r;
    pend_stamp_nxt = pend_stamp_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = scan_issue;
    rd_addr        = cnt_r;
    res            = '0;

    if (scan_issue) begin
      cnt_nxt = cnt_r + PAGE_LOG'(1);
      if (cnt_r == page_t'(PAGE_COUNT - 1)) issue_done_nxt = 1'b1;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        if (cnt_r == '0) begin
          wr_data.role  = ROLE_FREE;
          wr_data.order = pool_order;
        end
        cnt_nxt = cnt_r + PAGE_LOG'(1);
        if (cnt_r == page_t'(PAGE_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cnt_nxt        = '0;
        issue_done_nxt = 1'b0;
        if (start) begin
          if (kind == KIND_ALLOC) begin
            if ((request_bytes == '0) || (req_order > XLEN_W'(ORDER_COUNT - 1))) begin
              res.valid = 1'b1;
            end else begin
              ord_nxt   = req_order[ORDER_W-1:0];
              state_nxt = S_ASCAN;
            end
          end else begin
            if ((rel_off[PAGE_BYTES_LOG-1:0] != '0) ||
                (rel_off[ADDR_W-1:PAGE_BYTES_LOG+PAGE_LOG] != '0)) begin
              res.valid = 1'b1;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = rel_off[PAGE_BYTES_LOG +: PAGE_LOG];
              page_nxt  = rel_off[PAGE_BYTES_LOG +: PAGE_LOG];
              state_nxt = S_FLOOK;
            end
          end
        end
      end
      S_ASCAN: begin
        if (issue_done_r && !rd_vld_r) state_nxt = S_APICK;
      end
      S_APICK: begin
        if (!pick_found) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt    = pick_ord;
          page_nxt   = lane_page_r[pick_ord];
          pstamp_nxt = lane_stamp_r[pick_ord];
          state_nxt  = S_ASPLIT;
        end
      end
      S_ASPLIT: begin
        wr_en = 1'b1;
        if (cur_r > ord_r) begin
          // Push the upper half of the current block as the newest free block.
          cur_nxt       = cur_r - ORDER_W'(1);
          wr_addr       = page_r + (PAGE_LOG'(1) << cur_nxt);
          wr_data.role  = ROLE_FREE;
          wr_data.order = cur_nxt;
          wr_data.stamp = stamp_ctr_r;
          stamp_ctr_nxt = stamp_ctr_r + STAMP_W'(1);
        end else begin
          wr_addr       = page_r;
          wr_data.role  = ROLE_USED;
          wr_data.order = ord_r;
          wr_data.stamp = pstamp_r;
          res.valid     = 1'b1;
          res.ok        = 1'b1;
          res.addr      = base_address + (ADDR_W'(page_r) << PAGE_BYTES_LOG);
          state_nxt     = S_IDLE;
        end
      end
      S_FLOOK: begin
        if (rd_data.role != ROLE_USED) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = page_r;
          wr_data.role  = ROLE_FREE;
          wr_data.order = rd_data.order;
          wr_data.stamp = stamp_ctr_r;
          stamp_ctr_nxt = stamp_ctr_r + STAMP_W'(1);
          ord_nxt       = rd_data.order;
          if (rd_data.order >= TOP_ORDER) begin
            res.valid = 1'b1;
            res.ok    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            mfound_nxt = 1'b0;
            pend_nxt   = 1'b0;
            state_nxt  = S_MSCAN;
          end
        end
      end
      S_MSCAN: begin
        if (rd_vld_r) begin
          if ((rd_page_r & mask) == '0) begin
            // Aligned lower half: hold it until its buddy comes by.
            pend_nxt = (rd_data.role == ROLE_FREE) && (rd_data.order == ord_r);
            pend_stamp_nxt = rd_data.stamp;
          end else if (((rd_page_r & mask) == span) && pend_r) begin
            pend_nxt = 1'b0;
            if ((rd_data.role == ROLE_FREE) && (rd_data.order == ord_r) &&
                (!mfound_r || (pend_stamp_r > mstamp_r))) begin
              mfound_nxt = 1'b1;
              mpage_nxt  = rd_page_r - span;
              mstamp_nxt = pend_stamp_r;
            end
          end
        end
        if (issue_done_r && !rd_vld_r) begin
          if (!mfound_r) begin
            res.valid = 1'b1;
            res.ok    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MKILL;
          end
        end
      end
      S_MKILL: begin
        wr_en     = 1'b1;
        wr_addr   = mpage_r + span;
        state_nxt = S_MPUSH;
      end
      S_MPUSH: begin
        wr_en         = 1'b1;
        wr_addr       = mpage_r;
        wr_data.role  = ROLE_FREE;
        wr_data.order = ord_r + ORDER_W'(1);
        wr_data.stamp = stamp_ctr_r;
        stamp_ctr_nxt = stamp_ctr_r + STAMP_W'(1);
        ord_nxt       = ord_r + ORDER_W'(1);
        cnt_nxt        = '0;
        issue_done_nxt = 1'b0;
        mfound_nxt     = 1'b0;
        pend_nxt       = 1'b0;
        if (ord_nxt >= TOP_ORDER) begin
          res.valid = 1'b1;
          res.ok    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MSCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (init) begin
      state_nxt     = S_CLEAR;
      cnt_nxt       = '0;
      stamp_ctr_nxt = STAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      stamp_ctr_r  <= STAMP_W'(1);
      mfound_r     <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= scan_issue;
      stamp_ctr_r  <= stamp_ctr_nxt;
      mfound_r     <= mfound_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_page_r    <= cnt_r;
    ord_r        <= ord_nxt;
    cur_r        <= cur_nxt;
    page_r       <= page_nxt;
    pstamp_r     <= pstamp_nxt;
    mpage_r      <= mpage_nxt;
    mstamp_r     <= mstamp_nxt;
    pend_stamp_r <= pend_stamp_nxt;
  end

  // One lane per order tracks the newest free head seen during the alloc scan.
  always_ff @(posedge clk) begin
    for (int o = 0; o < ORDER_COUNT; o++) begin
      if (!rst_n || (state_r == S_IDLE)) begin
        lane_found_r[o] <= 1'b0;
      end else if ((state_r == S_ASCAN) && rd_vld_r && (rd_data.role == ROLE_FREE) &&
                   (rd_data.order == ORDER_W'(o)) &&
                   (!lane_found_r[o] || (rd_data.stamp > lane_stamp_r[o]))) begin
        lane_found_r[o] <= 1'b1;
        lane_page_r[o]  <= rd_page_r;
        lane_stamp_r[o] <= rd_data.stamp;
      end
    end
  end

  `BPA_ASSERT_IMPL(a_no_write_in_scan, (state_r == S_ASCAN) || (state_r == S_MSCAN), !wr_en)
  `BPA_ASSERT_NEXT(a_result_returns_idle, res.valid && !init, state_r == S_IDLE)
  `BPA_ASSERT_IMPL(a_split_above_target, state_r == S_ASPLIT, cur_r >= ord_r)
  `BPA_ASSERT_IMPL(a_merge_below_top, (state_r == S_MKILL) || (state_r == S_MSCAN),
                   ord_r < TOP_ORDER)

endmodule
`default_nettype wire

### rtl/buddy_page_allocator.sv
`default_nettype none
// Channel  Role       Transaction content
// in_      stream in  tuser = kind; tdata = request_bytes[23:0], release_address[55:24]
// out_     stream out tuser = ok; tdata = block_address[31:0]
// cfg_     APB        base_address at 0x0, pool_order at 0x4
//
// One item at a time. An allocate takes one scan of 1024 page entries through the
// single read port of the page memory, a pick step, then up to 10 split writes and
// the final write.
// A free takes a lookup, then one scan and two writes per merge level, for up to 10
// merge levels. The result waits in an output register.
// After reset and after every pool_order write, a clearing pass over the 1024 entries
// rewrites the page memory; no item is accepted during it.
module buddy_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // request_bytes[23:0], release_address[55:24]
  input  wire logic        in_tuser,   // kind[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // block_address[31:0]
  output logic             out_tuser,  // ok[0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bpa_pkg::*;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_POOL = 1'b1;

  logic [ADDR_W-1:0] base_r;
  order_t            pool_r;
  logic              out_vld_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_ok_r;
  logic              cfg_wr;
  logic              init;
  logic              eng_ready;
  logic              start;
  order_t            pool_wr;
  res_t              res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign init       = cfg_wr && (cfg_paddr[2] == REG_POOL);
  // Saturate the pool order at the largest order.
  assign pool_wr    = (cfg_pwdata[ORDER_W-1:0] > ORDER_W'(ORDER_COUNT - 1)) ?
                      ORDER_W'(ORDER_COUNT - 1) : cfg_pwdata[ORDER_W-1:0];
  assign cfg_prdata = (cfg_paddr[2] == REG_BASE) ? base_r : 32'(pool_r);

  assign in_tready  = eng_ready && !out_vld_r;
  assign start      = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_ok_r;

  bpa_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .init            (init),
    .base_address    (base_r),
    .pool_order      (pool_r),
    .start           (start),
    .kind            (in_tuser),
    .request_bytes   (in_tdata[23:0]),
    .release_address (in_tdata[55:24]),
    .ready           (eng_ready),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      pool_r    <= ORDER_W'(6);
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr[2] == REG_BASE)) base_r <= cfg_pwdata;
      if (init) pool_r <= pool_wr;
      if (res.valid) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_addr_r <= res.addr;
      out_ok_r   <= res.ok;
    end
  end

endmodule
`default_nettype wire

### test/buddy_page_allocator_test.sv
`timescale 1ns / 100ps
`default_nettype none
module buddy_page_allocator_test;
  import bpa_pkg::*;

  localparam logic [2:0] REG_BASE       = 3'd0;
  localparam logic [2:0] REG_POOL_ORDER = 3'd4;
  localparam int MAX_ORDER = ORDER_COUNT - 1;

  typedef struct packed {
    logic        kind;
    logic [23:0] req_bytes;
    logic [31:0] rel_addr;
  } request_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        ok;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // request_bytes[23:0], release_address[55:24]
  logic        in_tuser;   // kind[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // block_address[31:0]
  logic        out_tuser;  // ok[0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  buddy_page_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Allocator shadow state
  logic [31:0] pool_base;
  logic [3:0]  pool_ord;
  logic [1:0]  pg_role [PAGE_COUNT];
  logic [3:0]  pg_order[PAGE_COUNT];
  logic [31:0] pg_stamp[PAGE_COUNT];
  logic [31:0] next_stamp;
  int          live_pages[$];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  request_t cur_req;
  int  issued, accepted;
  int  errors;
  int  n_alloc_ok, n_alloc_fail, n_free_ok, n_free_fail;
  bit  quiet;
  int  send_gap, recv_stall;

  function automatic void reinit_pool();
    for (int p = 0; p < PAGE_COUNT; p++) begin
      pg_role[p]  = ROLE_NONE;
      pg_order[p] = '0;
      pg_stamp[p] = '0;
    end
    pg_role[0]  = ROLE_FREE;
    pg_order[0] = pool_ord;
    next_stamp  = 32'd1;
    live_pages.delete();
  endfunction

  function automatic void push_free_block(int pg, int ord);
    pg_role[pg]  = ROLE_FREE;
    pg_order[pg] = ord[3:0];
    pg_stamp[pg] = next_stamp;
    next_stamp   = next_stamp + 32'd1;
  endfunction

  // Newest free head of an order; with pair set, only lower halves of free pairs
  function automatic bit newest_free(int ord, bit pair, output int pg);
    bit          hit;
    logic [31:0] best_stamp;
    int          span;
    hit = 0;
    pg = 0;
    best_stamp = '0;
    span = 1 << ord;
    for (int p = 0; p < PAGE_COUNT; p++) begin
      if (pg_role[p] != ROLE_FREE || pg_order[p] != ord) continue;
      if (pair) begin
        if ((p % (2 * span)) != 0 || p + span >= PAGE_COUNT) continue;
        if (pg_role[p + span] != ROLE_FREE || pg_order[p + span] != ord) continue;
      end
      if (!hit || pg_stamp[p] > best_stamp) begin
        hit = 1;
        pg = p;
        best_stamp = pg_stamp[p];
      end
    end
    return hit;
  endfunction

  function automatic answer_t allocator_answer(request_t r);
    answer_t     a;
    logic [23:0] x;
    int          ord, cur, pg, lower;
    logic [31:0] off;
    a = '0;
    if (r.kind == KIND_ALLOC) begin
      if (r.req_bytes == 0) return a;
      x = (r.req_bytes - 24'd1) >> PAGE_BYTES_LOG;
      ord = 0;
      while (x != 0) begin
        x = x >> 1;
        ord++;
      end
      if (ord > MAX_ORDER) return a;
      for (cur = ord; cur <= MAX_ORDER; cur++)
        if (newest_free(cur, 0, pg)) break;
      if (cur > MAX_ORDER) return a;
      while (cur > ord) begin
        cur--;
        push_free_block(pg + (1 << cur), cur);
      end
      pg_role[pg]  = ROLE_USED;
      pg_order[pg] = ord[3:0];
      live_pages.push_back(pg);
      a.addr = pool_base + (32'(pg) << PAGE_BYTES_LOG);
      a.ok = 1'b1;
    end else begin
      off = r.rel_addr - pool_base;
      if (off[PAGE_BYTES_LOG-1:0] != 0) return a;
      if ((off >> PAGE_BYTES_LOG) >= PAGE_COUNT) return a;
      pg = int'(off >> PAGE_BYTES_LOG);
      if (pg_role[pg] != ROLE_USED) return a;
      foreach (live_pages[i])
        if (live_pages[i] == pg) begin
          live_pages.delete(i);
          break;
        end
      ord = int'(pg_order[pg]);
      push_free_block(pg, ord);
      while (ord < MAX_ORDER) begin
        if (!newest_free(ord, 1, lower)) break;
        pg_role[lower + (1 << ord)]  = ROLE_NONE;
        pg_order[lower + (1 << ord)] = '0;
        pg_stamp[lower + (1 << ord)] = '0;
        ord++;
        push_free_block(lower, ord);
      end
      a.ok = 1'b1;
    end
    return a;
  endfunction

  // Request driver
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      send_gap  <= 0;
    end else if (in_tvalid && in_tready) begin
      a = allocator_answer(cur_req);
      expected_answers.push_back(a);
      if (cur_req.kind == KIND_ALLOC) begin
        if (a.ok) n_alloc_ok++; else n_alloc_fail++;
      end else begin
        if (a.ok) n_free_ok++; else n_free_fail++;
      end
      accepted++;
      in_tvalid <= 1'b0;
      send_gap  <= quiet ? 0 : int'($urandom_range(0, 8));
    end else if (!in_tvalid) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cur_req.kind;
        in_tdata  <= {cur_req.rel_addr, cur_req.req_bytes};
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    answer_t e;
    int      s;
    if (!rst_n) begin
      out_tready <= 1'b1;
      recv_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result: block_address %h ok %b", out_tdata, out_tuser);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (out_tdata !== e.addr) begin
          $error("block_address: expected %h, got %h", e.addr, out_tdata);
          errors++;
        end
        if (out_tuser !== e.ok) begin
          $error("ok: expected %b, got %b", e.ok, out_tuser);
          errors++;
        end
      end
      s = quiet ? 0 : int'($urandom_range(0, 8));
      if (s != 0) begin
        out_tready <= 1'b0;
        recv_stall <= s;
      end
    end else if (!out_tready) begin
      if (recv_stall <= 1) out_tready <= 1'b1;
      recv_stall <= recv_stall - 1;
    end
  end

  task automatic send(logic kind, logic [23:0] bytes, logic [31:0] rel);
    request_t r;
    r.kind = kind;
    r.req_bytes = bytes;
    r.rel_addr = rel;
    pending_reqs.push_back(r);
    issued++;
    // hold until the shadow state has seen this transaction
    while (accepted != issued) @(posedge clk);
  endtask

  task automatic drain();
    while (accepted != issued || expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == REG_BASE) begin
      pool_base = data;
    end else begin
      pool_ord = (data[3:0] > MAX_ORDER) ? 4'(MAX_ORDER) : data[3:0];
      reinit_pool();
    end
  endtask

  function automatic logic [31:0] live_addr();
    return pool_base + (32'(live_pages[$urandom_range(0, live_pages.size() - 1)])
                        << PAGE_BYTES_LOG);
  endfunction

  task automatic random_phase(int count);
    int          pick;
    logic [23:0] bytes;
    logic [31:0] addr;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      quiet = ($urandom_range(0, 9) < 2);
      pick = int'($urandom_range(0, 99));
      if (live_pages.size() > 0 && pick < 45) begin
        send(KIND_FREE, 24'($urandom()), live_addr());
      end else if (pick < 52) begin
        // noise: misaligned, foreign or stale addresses
        addr = $urandom();
        if ($urandom_range(0, 1)) addr = pool_base + (addr & 32'h000F_FC00);
        send(KIND_FREE, 24'($urandom()), addr);
      end else begin
        if (pick < 57) bytes = 24'($urandom());
        else bytes = 24'($urandom_range(1, 1 << (PAGE_BYTES_LOG + $urandom_range(0, 5))));
        send(KIND_ALLOC, bytes, $urandom());
      end
    end
    quiet = 0;
    drain();
  endtask

  initial begin
    logic [31:0] a;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    issued = 0;
    accepted = 0;
    errors = 0;
    quiet = 0;
    n_alloc_ok = 0;
    n_alloc_fail = 0;
    n_free_ok = 0;
    n_free_fail = 0;
    pool_base = '0;
    pool_ord = 4'd6;
    reinit_pool();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: sizes at the edges, bad frees, double free
    send(KIND_ALLOC, 24'd0, 32'hFFFF_FFFF);
    send(KIND_ALLOC, 24'hFF_FFFF, 32'h0);
    send(KIND_ALLOC, 24'd1 << 20, 32'h0);
    send(KIND_ALLOC, 24'd1, 32'h0);
    send(KIND_ALLOC, 24'd1024, 32'h0);
    send(KIND_ALLOC, 24'd1025, 32'h0);
    send(KIND_ALLOC, 24'd4096, 32'h0);
    send(KIND_FREE, 24'hFF_FFFF, 32'h0000_0001);
    send(KIND_FREE, 24'h0, 32'hFFFF_FC00);
    send(KIND_FREE, 24'h0, 32'h0010_0000);
    send(KIND_FREE, 24'h0, 32'h0000_0000);
    send(KIND_FREE, 24'h0, 32'h0000_0000);
    send(KIND_ALLOC, 24'd65536, 32'h0);
    send(KIND_ALLOC, 24'd65537, 32'h0);
    while (live_pages.size() > 0) send(KIND_FREE, 24'h0, live_addr());
    send(KIND_ALLOC, 24'd65536, 32'h0);
    drain();

    // moving the base leaves the pool as is; old blocks are found at the new base
    cfg_write(REG_BASE, 32'hFFFF_F000);
    send(KIND_ALLOC, 24'd2048, 32'h0);
    drain();
    a = live_addr();
    send(KIND_FREE, 24'h0, a);
    send(KIND_FREE, 24'h0, 32'hFFFF_F000);
    drain();

    cfg_write(REG_POOL_ORDER, 32'd15);
    random_phase(60);
    cfg_write(REG_BASE, 32'h0);
    cfg_write(REG_POOL_ORDER, 32'd0);
    random_phase(25);
    cfg_write(REG_BASE, $urandom());
    cfg_write(REG_POOL_ORDER, 32'd10);
    random_phase(70);
    cfg_write(REG_BASE, 32'hFFFF_FFFF);
    cfg_write(REG_POOL_ORDER, 32'd3);
    random_phase(40);
    cfg_write(REG_POOL_ORDER, 32'd7);
    random_phase(35);
    cfg_write(REG_BASE, $urandom() & 32'hFFFF_FC00);
    random_phase(35);

    drain();
    repeat (2100) @(posedge clk);
    $display("covered %0d allocations (%0d refused) and %0d frees (%0d unknown)",
             n_alloc_ok + n_alloc_fail, n_alloc_fail, n_free_ok + n_free_fail, n_free_fail);
    $display("over pool orders 0 to 10 with saturation and several base addresses");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400ms;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
